/* hw/rtl/lsf_pkg.sv */
package lsf_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int NUM_PORTS   = 8;

    localparam int ADDR_W   = 8;
    localparam int PORT_W   = 3;
    localparam int MASK_W   = 8;
    localparam int LIMIT_W  = 4;
    localparam int TBL_AW   = $clog2(TABLE_DEPTH);
    localparam int TBL_CW   = $clog2(TABLE_DEPTH + 1);
    localparam int CFG_AW   = 1;

    localparam logic [CFG_AW-1:0] REG_TREE_PORT_MASK = 1'd0;
    localparam logic [CFG_AW-1:0] REG_PORTS_IN_USE   = 1'd1;

    localparam logic [LIMIT_W-1:0] PORTS_IN_USE_RST = 4'd8;

    typedef enum logic {
        S_IDLE,
        S_LOOKUP
    } t_state;

    typedef struct packed {
        logic accept;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_stat;

endpackage

/* hw/rtl/lsf_hdr_if.sv */
interface lsf_hdr_if;
    import lsf_pkg::*;

    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] src_addr;
    logic [ADDR_W-1:0] dst_addr;
    logic [PORT_W-1:0] in_port;

    modport source (output valid, src_addr, dst_addr, in_port, input ready);
    modport sink   (input valid, src_addr, dst_addr, in_port, output ready);
endinterface

/* hw/rtl/lsf_res_if.sv */
interface lsf_res_if;
    import lsf_pkg::*;

    logic              valid;
    logic              ready;
    logic [MASK_W-1:0] out_port_mask;
    logic              dst_known;
    logic              src_learned;
    logic              table_full;

    modport source (output valid, out_port_mask, dst_known, src_learned, table_full,
                    input ready);
    modport sink   (input valid, out_port_mask, dst_known, src_learned, table_full,
                    output ready);
endinterface

/* hw/rtl/lsf_cfg_if.sv */
interface lsf_cfg_if;
    import lsf_pkg::*;

    logic              valid;
    logic              ready;
    logic [CFG_AW-1:0] addr;
    logic [MASK_W-1:0] data;

    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface

/* hw/rtl/lsf_ctrl.sv */
module lsf_ctrl
    import lsf_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_hdr_valid,
    output logic  o_hdr_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_hdr_ready = 1'b0;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                // learn the source on the accept edge; take nothing in reset
                o_hdr_ready = i_rst_n;
                if (i_hdr_valid && i_rst_n) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                // hold until the output register can take the result
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

/* hw/rtl/lsf_dp.sv */
module lsf_dp
    import lsf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_stat             o_stat,
    input  logic [ADDR_W-1:0] i_src_addr,
    input  logic [ADDR_W-1:0] i_dst_addr,
    input  logic [PORT_W-1:0] i_in_port,
    input  logic              i_cfg_we,
    input  logic [CFG_AW-1:0] i_cfg_addr,
    input  logic [MASK_W-1:0] i_cfg_data,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output logic [MASK_W-1:0] o_out_port_mask,
    output logic              o_dst_known,
    output logic              o_src_learned,
    output logic              o_table_full
);

    logic [ADDR_W-1:0]  r_keys  [TABLE_DEPTH];
    logic [PORT_W-1:0]  r_ports [TABLE_DEPTH];
    logic [TBL_CW-1:0]  r_used;
    logic [MASK_W-1:0]  r_tree_mask;
    logic [LIMIT_W-1:0] r_ports_in_use;

    logic [ADDR_W-1:0]  r_dst;
    logic [PORT_W-1:0]  r_in_port;
    logic               r_learned;
    logic               r_full;

    logic               r_out_valid;
    logic [MASK_W-1:0]  r_out_mask;
    logic               r_out_known;
    logic               r_out_learned;
    logic               r_out_full;

    logic               src_hit;
    logic               dst_hit;
    logic [TBL_AW-1:0]  dst_slot;
    logic               tbl_has_room;
    logic               do_learn;
    logic [PORT_W-1:0]  dst_port;
    logic               n_known;
    logic [MASK_W-1:0]  n_mask;
    logic [LIMIT_W-1:0] limit;

    // parallel compare over valid entries; keys are unique so the hit is one-hot
    always_comb begin
        src_hit  = 1'b0;
        dst_hit  = 1'b0;
        dst_slot = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (TBL_CW'(i) < r_used) begin
                if (r_keys[i] == i_src_addr) begin
                    src_hit = 1'b1;
                end
                if (r_keys[i] == r_dst) begin
                    dst_hit  = 1'b1;
                    dst_slot = dst_slot | TBL_AW'(i);
                end
            end
        end
    end

    assign tbl_has_room = (r_used < TBL_CW'(TABLE_DEPTH));
    assign do_learn     = i_cmd.accept && !src_hit && tbl_has_room;
    assign dst_port     = r_ports[dst_slot];

    always_comb begin
        limit = r_ports_in_use;
        if (limit > LIMIT_W'(NUM_PORTS)) begin
            limit = LIMIT_W'(NUM_PORTS);
        end
        if (limit > LIMIT_W'(MASK_W)) begin
            limit = LIMIT_W'(MASK_W);
        end
        n_known = dst_hit && r_tree_mask[dst_port];
        n_mask  = '0;
        if (n_known) begin
            n_mask[dst_port] = 1'b1;
        end else begin
            for (int k = 0; k < MASK_W; k++) begin
                n_mask[k] = (LIMIT_W'(k) < limit) && (PORT_W'(k) != r_in_port)
                            && r_tree_mask[k];
            end
        end
    end

    assign o_stat.out_free = !r_out_valid || i_res_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used         <= '0;
            r_tree_mask    <= '0;
            r_ports_in_use <= PORTS_IN_USE_RST;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_TREE_PORT_MASK: r_tree_mask    <= i_cfg_data;
                    REG_PORTS_IN_USE:   r_ports_in_use <= i_cfg_data[LIMIT_W-1:0];
                    default: ;
                endcase
            end
            if (do_learn) begin
                r_used <= r_used + 1'b1;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_learn) begin
            r_keys[r_used[TBL_AW-1:0]]  <= i_src_addr;
            r_ports[r_used[TBL_AW-1:0]] <= i_in_port;
        end
        if (i_cmd.accept) begin
            r_dst     <= i_dst_addr;
            r_in_port <= i_in_port;
            r_learned <= !src_hit && tbl_has_room;
            r_full    <= !src_hit && !tbl_has_room;
        end
        if (i_cmd.emit) begin
            r_out_mask    <= n_mask;
            r_out_known   <= n_known;
            r_out_learned <= r_learned;
            r_out_full    <= r_full;
        end
    end

    assign o_res_valid     = r_out_valid;
    assign o_out_port_mask = r_out_mask;
    assign o_dst_known     = r_out_known;
    assign o_src_learned   = r_out_learned;
    assign o_table_full    = r_out_full;

endmodule

/* hw/rtl/learning_switch_forwarder_top.sv */
// Learning switch address table and forwarder.
// i_hdr carries one packet header per transaction (source, destination,
// ingress port). o_res returns one forwarding decision per header: the
// egress port mask, whether the destination was a known in-tree unicast,
// and whether the source was learned or dropped because the table is full.
// i_cfg writes the tree port mask (index 0) and the attached port count
// (index 1); it is ready outside reset and should be used only while idle.
// The source is compared against all learned entries and appended on the
// accept cycle; the destination lookup runs in the following cycle and the
// result is registered once the output register is free.
// A header is taken only from the idle state, never while one is in lookup.
// A stalled receiver holds the result register; the header in lookup waits
// for it and no new header is taken meanwhile.
// Reset empties the table, clears the tree mask and sets the port count to 8;
// no transaction is taken while reset is asserted.
module learning_switch_forwarder_top
    import lsf_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    lsf_hdr_if.sink   i_hdr,
    lsf_res_if.source o_res,
    lsf_cfg_if.sink   i_cfg
);

    t_cmd  cmd;
    t_stat stat;
    logic  hdr_ready;

    assign i_hdr.ready = hdr_ready;
    assign i_cfg.ready = i_rst_n;

    lsf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_hdr_valid (i_hdr.valid),
        .o_hdr_ready (hdr_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    lsf_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_src_addr      (i_hdr.src_addr),
        .i_dst_addr      (i_hdr.dst_addr),
        .i_in_port       (i_hdr.in_port),
        .i_cfg_we        (i_cfg.valid),
        .i_cfg_addr      (i_cfg.addr),
        .i_cfg_data      (i_cfg.data),
        .o_res_valid     (o_res.valid),
        .i_res_ready     (o_res.ready),
        .o_out_port_mask (o_res.out_port_mask),
        .o_dst_known     (o_res.dst_known),
        .o_src_learned   (o_res.src_learned),
        .o_table_full    (o_res.table_full)
    );

endmodule

/* bench/tb_learning_switch_forwarder_top.sv */
`timescale 1ns / 100ps

module tb_learning_switch_forwarder_top;
    import lsf_pkg::*;

    localparam int IDLE_LIMIT = 2000;
    localparam int HOLD_CYCLES = 150;
    localparam int HOLD_AT = 400;
    localparam int PHASES = 7;
    localparam int ITEMS_PER_PHASE = 150;

    typedef struct packed {
        logic [MASK_W-1:0] mask;
        logic              known;
        logic              learned;
        logic              full;
    } t_fwd;

    typedef enum bit {
        ROW_CFG,
        ROW_HDR
    } t_row_kind;

    typedef struct {
        t_row_kind         kind;
        logic [CFG_AW-1:0] reg_idx;
        logic [MASK_W-1:0] data;
        logic [ADDR_W-1:0] src;
        logic [ADDR_W-1:0] dst;
        logic [PORT_W-1:0] port;
        bit                typed;
        t_fwd              want;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    lsf_hdr_if hdr_if ();
    lsf_res_if res_if ();
    lsf_cfg_if cfg_if ();

    learning_switch_forwarder_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_hdr   (hdr_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    // Shadow copy of the address table and registers
    logic [ADDR_W-1:0]  tbl_keys [TABLE_DEPTH];
    logic [PORT_W-1:0]  tbl_ports[TABLE_DEPTH];
    int                 tbl_used = 0;
    logic [MASK_W-1:0]  tree_mask = '0;
    logic [LIMIT_W-1:0] port_limit = PORTS_IN_USE_RST;

    t_fwd fwd_expected[$];
    t_row rows[$];

    // Travels with the header so the monitor knows which expectation applies
    bit   hdr_typed;
    t_fwd hdr_want;

    int fail_count = 0;
    int hdr_count = 0;
    int results_seen = 0;
    int learned_count = 0;
    int full_count = 0;
    int unicast_count = 0;
    int settings_count = 0;
    int idle_cycles = 0;
    bit send_calm = 0;
    bit recv_calm = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic int find_entry(logic [ADDR_W-1:0] key);
        for (int i = 0; i < tbl_used; i++) begin
            if (tbl_keys[i] == key) return i;
        end
        return -1;
    endfunction

    function automatic t_fwd forward_decision(logic [ADDR_W-1:0] src, logic [ADDR_W-1:0] dst,
                                              logic [PORT_W-1:0] port);
        t_fwd r;
        int   hit;
        int   lim;
        r = '0;
        hit = find_entry(src);
        if (hit < 0) begin
            if (tbl_used < TABLE_DEPTH) begin
                tbl_keys[tbl_used] = src;
                tbl_ports[tbl_used] = port;
                tbl_used++;
                r.learned = 1'b1;
            end else begin
                r.full = 1'b1;
            end
        end
        hit = find_entry(dst);
        if (hit >= 0 && tbl_ports[hit] < MASK_W && tree_mask[tbl_ports[hit]]) begin
            r.mask[tbl_ports[hit]] = 1'b1;
            r.known = 1'b1;
        end
        if (!r.known) begin
            lim = port_limit;
            if (lim > NUM_PORTS) lim = NUM_PORTS;
            if (lim > MASK_W) lim = MASK_W;
            for (int k = 0; k < lim; k++) begin
                if (k != port && tree_mask[k]) r.mask[k] = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic int draw_wait(inout bit calm);
        if ($urandom_range(0, 39) == 0) calm = !calm;
        if (calm) return 0;
        return $urandom_range(0, 18);
    endfunction

    // Favor addresses already in the table so lookups hit
    function automatic logic [ADDR_W-1:0] pick_addr();
        if (tbl_used > 0 && $urandom_range(0, 99) < 60)
            return tbl_keys[$urandom_range(0, tbl_used - 1)];
        return ADDR_W'($urandom_range(0, 255));
    endfunction

    function automatic void add_cfg(logic [CFG_AW-1:0] idx, logic [MASK_W-1:0] data);
        t_row r;
        r = '{kind: ROW_CFG, reg_idx: idx, data: data, default: '0};
        rows.push_back(r);
    endfunction

    function automatic void add_hdr(logic [ADDR_W-1:0] src, logic [ADDR_W-1:0] dst,
                                    logic [PORT_W-1:0] port, bit typed, t_fwd want);
        t_row r;
        r = '{kind: ROW_HDR, src: src, dst: dst, port: port, typed: typed, want: want,
              default: '0};
        rows.push_back(r);
    endfunction

    task automatic send_hdr(logic [ADDR_W-1:0] src, logic [ADDR_W-1:0] dst,
                            logic [PORT_W-1:0] port, bit typed, t_fwd want);
        int gap;
        gap = draw_wait(send_calm);
        if (gap > 0) begin
            hdr_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        hdr_if.valid    <= 1'b1;
        hdr_if.src_addr <= src;
        hdr_if.dst_addr <= dst;
        hdr_if.in_port  <= port;
        hdr_typed       <= typed;
        hdr_want        <= want;
        do @(posedge i_clk); while (!(hdr_if.valid && hdr_if.ready));
    endtask

    // Drop the header valid and wait until every decision has come back
    task automatic drain();
        hdr_if.valid <= 1'b0;
        @(posedge i_clk);
        while (fwd_expected.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_AW-1:0] idx, logic [MASK_W-1:0] data);
        drain();
        cfg_if.valid <= 1'b1;
        cfg_if.addr  <= idx;
        cfg_if.data  <= data;
        do @(posedge i_clk); while (!(cfg_if.valid && cfg_if.ready));
        cfg_if.valid <= 1'b0;
        settings_count++;
    endtask

    // Stimulus
    initial begin
        logic [MASK_W-1:0] mask_val;
        logic [3:0]        limit_val;
        i_rst_n         <= 1'b0;
        hdr_if.valid    <= 1'b0;
        hdr_if.src_addr <= '0;
        hdr_if.dst_addr <= '0;
        hdr_if.in_port  <= '0;
        hdr_typed       <= 1'b0;
        hdr_want        <= '0;
        cfg_if.valid    <= 1'b0;
        cfg_if.addr     <= REG_TREE_PORT_MASK;
        cfg_if.data     <= '0;

        // Reset values: empty tree, all eight ports attached
        add_hdr(8'h00, 8'hFF, 3'd0, 1, t_fwd'{8'h00, 1'b0, 1'b1, 1'b0});
        add_hdr(8'hFF, 8'h00, 3'd7, 1, t_fwd'{8'h00, 1'b0, 1'b1, 1'b0});
        add_cfg(REG_TREE_PORT_MASK, 8'hFF);
        // known source arriving on another port keeps its old entry
        add_hdr(8'h00, 8'hFF, 3'd5, 1, t_fwd'{8'h80, 1'b1, 1'b0, 1'b0});
        // source equal to destination hits the fresh entry
        add_hdr(8'h5A, 8'h5A, 3'd2, 1, t_fwd'{8'h04, 1'b1, 1'b1, 1'b0});
        // unicast back out of the ingress port
        add_hdr(8'h11, 8'h00, 3'd0, 1, t_fwd'{8'h01, 1'b1, 1'b1, 1'b0});
        add_hdr(8'h22, 8'h99, 3'd3, 1, t_fwd'{8'hF7, 1'b0, 1'b1, 1'b0});
        // learned port outside the tree falls back to flooding
        add_cfg(REG_TREE_PORT_MASK, 8'h7E);
        add_hdr(8'h33, 8'h00, 3'd4, 1, t_fwd'{8'h6E, 1'b0, 1'b1, 1'b0});
        add_cfg(REG_PORTS_IN_USE, 8'd0);
        add_hdr(8'h44, 8'h98, 3'd1, 1, t_fwd'{8'h00, 1'b0, 1'b1, 1'b0});
        add_cfg(REG_TREE_PORT_MASK, 8'hFF);
        add_cfg(REG_PORTS_IN_USE, 8'd15);
        add_hdr(8'h55, 8'h97, 3'd0, 1, t_fwd'{8'hFE, 1'b0, 1'b1, 1'b0});
        add_cfg(REG_PORTS_IN_USE, 8'd3);
        add_hdr(8'h55, 8'h96, 3'd1, 1, t_fwd'{8'h05, 1'b0, 1'b0, 1'b0});
        add_cfg(REG_PORTS_IN_USE, 8'd1);
        add_hdr(8'h66, 8'h95, 3'd0, 1, t_fwd'{8'h00, 1'b0, 1'b1, 1'b0});
        add_cfg(REG_PORTS_IN_USE, 8'd9);
        add_cfg(REG_TREE_PORT_MASK, 8'hA5);
        add_hdr(8'hAA, 8'h55, 3'd6, 0, '0);
        add_hdr(8'h5A, 8'h11, 3'd7, 0, '0);
        add_hdr(8'hC3, 8'h22, 3'd1, 0, '0);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) begin
            if (rows[i].kind == ROW_CFG)
                write_reg(rows[i].reg_idx, rows[i].data);
            else
                send_hdr(rows[i].src, rows[i].dst, rows[i].port, rows[i].typed,
                         rows[i].want);
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            mask_val  = MASK_W'($urandom_range(0, 255));
            limit_val = 4'($urandom_range(0, 15));
            case (ph)
                0: begin mask_val = 8'hFF; limit_val = 4'd8; end
                1: begin mask_val = 8'h00; limit_val = 4'd8; end
                2: limit_val = 4'd15;
                3: limit_val = 4'd0;
                4: begin mask_val = 8'hFF; limit_val = 4'd1; end
                5: limit_val = 4'd9;
                default: ;
            endcase
            write_reg(REG_TREE_PORT_MASK, mask_val);
            // upper data bits do not belong to the port count
            write_reg(REG_PORTS_IN_USE, {4'($urandom_range(0, 15)), limit_val});
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send_hdr(pick_addr(), pick_addr(), PORT_W'($urandom_range(0, 7)), 0, '0);
        end

        drain();
        repeat (8) @(posedge i_clk);
        $display("Forwarded %0d headers under %0d register writes: %0d sources learned,",
                 hdr_count, settings_count, learned_count);
        $display("%0d dropped for a full table, %0d unicast, %0d flooded.",
                 full_count, unicast_count, hdr_count - unicast_count);
        if (fail_count == 0 && fwd_expected.size() == 0) begin
            $display("tb_learning_switch_forwarder_top passed");
        end else begin
            $display("tb_learning_switch_forwarder_top failed");
        end
        $finish;
    end

    // Result receiver: random stalls, one long hold-off to back up the block
    initial begin
        int  stall;
        bit  held;
        held = 0;
        res_if.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = draw_wait(recv_calm);
            if (!held && results_seen >= HOLD_AT) begin
                stall = HOLD_CYCLES;
                held = 1;
            end
            if (stall > 0) begin
                res_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge i_clk); while (!(res_if.valid && res_if.ready));
        end
    end

    // Transaction monitor: predict on header acceptance, check on result acceptance
    always @(posedge i_clk) begin
        t_fwd pred;
        t_fwd want;
        if (i_rst_n) begin
            if (res_if.valid && res_if.ready) begin
                results_seen++;
                if (fwd_expected.size() == 0) begin
                    $error("forwarding result with no header outstanding");
                    fail_count++;
                end else begin
                    want = fwd_expected.pop_front();
                    if (res_if.out_port_mask !== want.mask) begin
                        $error("out_port_mask: expected %h, got %h", want.mask,
                               res_if.out_port_mask);
                        fail_count++;
                    end
                    if (res_if.dst_known !== want.known) begin
                        $error("dst_known: expected %b, got %b", want.known, res_if.dst_known);
                        fail_count++;
                    end
                    if (res_if.src_learned !== want.learned) begin
                        $error("src_learned: expected %b, got %b", want.learned,
                               res_if.src_learned);
                        fail_count++;
                    end
                    if (res_if.table_full !== want.full) begin
                        $error("table_full: expected %b, got %b", want.full, res_if.table_full);
                        fail_count++;
                    end
                end
            end
            if (cfg_if.valid && cfg_if.ready) begin
                case (cfg_if.addr)
                    REG_TREE_PORT_MASK: tree_mask = cfg_if.data;
                    REG_PORTS_IN_USE:   port_limit = cfg_if.data[LIMIT_W-1:0];
                    default: ;
                endcase
            end
            if (hdr_if.valid && hdr_if.ready) begin
                pred = forward_decision(hdr_if.src_addr, hdr_if.dst_addr, hdr_if.in_port);
                hdr_count++;
                learned_count += pred.learned;
                full_count += pred.full;
                unicast_count += pred.known;
                fwd_expected.push_back(hdr_typed ? hdr_want : pred);
            end
        end
    end

    // Watchdog: end the run if no transaction moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (hdr_if.valid && hdr_if.ready) || (res_if.valid && res_if.ready)
            || (cfg_if.valid && cfg_if.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_learning_switch_forwarder_top failed");
            $finish;
        end
    end

endmodule

/* filelist.f */
hw/rtl/lsf_pkg.sv
hw/rtl/lsf_hdr_if.sv
hw/rtl/lsf_res_if.sv
hw/rtl/lsf_cfg_if.sv
hw/rtl/lsf_ctrl.sv
hw/rtl/lsf_dp.sv
hw/rtl/learning_switch_forwarder_top.sv
bench/tb_learning_switch_forwarder_top.sv
